// ===== rtl/core/ppq_pkg.sv =====
// ----------------------------------------------------------------------------
// ppq_pkg : shared types and constants of the point-plane query engine
// Item formats, plane registers, stage structs and a saturation helper.
// ----------------------------------------------------------------------------
package ppq_pkg;

   localparam int COORD_FRAC_BITS = 16;   // fraction bits of a coordinate
   localparam int NORM_FRAC       = 30;   // fraction bits of a normal component
   localparam int CW       = 32;          // coordinate and register width
   localparam int DIFF_W   = CW + 1;      // P - B
   localparam int DPROD_W  = DIFF_W + CW; // (P - B) * n
   localparam int RPROD_W  = 2 * CW;      // D * n
   localparam int DOT_W    = DPROD_W + 2; // sum of three products
   localparam int SD_W     = DOT_W - NORM_FRAC;
   localparam int PROD_W   = SD_W + CW + 1;
   localparam int EXT_W    = CW + 9;      // foot and image before saturation
   localparam int UW       = DOT_W;       // divider operand magnitude
   localparam int RW       = UW + 1;      // divider partial remainder
   localparam int QW       = CW;          // quotient bits produced
   localparam int CSR_IDX_W = 3;

   localparam logic [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_X = 3'd0,
      CSR_BASE_Y = 3'd1,
      CSR_BASE_Z = 3'd2,
      CSR_NORM_X = 3'd3,
      CSR_NORM_Y = 3'd4,
      CSR_NORM_Z = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CW-1:0] query_x;
      logic [CW-1:0] query_y;
      logic [CW-1:0] query_z;
      logic [CW-1:0] ray_dx;
      logic [CW-1:0] ray_dy;
      logic [CW-1:0] ray_dz;
   } req_type;

   typedef struct packed {
      logic [CW-1:0]   signed_dist;
      logic [CW-2:0]   abs_dist;
      logic [CW-1:0]   foot_x;
      logic [CW-1:0]   foot_y;
      logic [CW-1:0]   foot_z;
      logic            below_plane;
      logic [CW-1:0]   image_x;
      logic [CW-1:0]   image_y;
      logic [CW-1:0]   image_z;
      logic [CW-1:0]   hit_param;
      logic            no_hit;
   } rsp_type;

   typedef struct packed {
      logic [2:0][CW-1:0] base;
      logic [2:0][CW-1:0] norm;
   } plane_type;

   // Front end to geometry stages.
   typedef struct packed {
      logic [SD_W-1:0]    sd;
      logic               below;
      logic [2:0][CW-1:0] p;
      logic [UW-1:0]      un;
      logic [UW-1:0]      ud;
      logic               neg;
      logic               no_hit;
   } front_type;

   // Geometry stages to divider.
   typedef struct packed {
      logic [UW-1:0] un;
      logic [UW-1:0] ud;
      logic          neg;
      logic          no_hit;
      rsp_type       rsp;
   } div_in_type;

   // Saturate a wide signed value to a 32-bit coordinate.
   function automatic logic [CW-1:0] sat_coord(input logic [EXT_W-1:0] v);
      logic [CW-1:0] r;
      if (v[EXT_W-1:CW-1] == {(EXT_W-CW+1){1'b0}} ||
          v[EXT_W-1:CW-1] == {(EXT_W-CW+1){1'b1}}) begin
         r = v[CW-1:0];
      end else if (v[EXT_W-1]) begin
         r = SMIN;
      end else begin
         r = SMAX;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/ppq_front.sv =====
// ----------------------------------------------------------------------------
// ppq_front : signed distance front end
// Four stages: difference, products, dot sums, rounding and magnitudes.
// ----------------------------------------------------------------------------
module ppq_front import ppq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      adv,
   input  logic      in_valid,
   input  req_type   in_data,
   input  plane_type plane,
   output logic      out_valid,
   output front_type out_data
);

   localparam logic [DOT_W-1:0] HALF30 = DOT_W'(1) << (NORM_FRAC - 1);

   logic [3:0] vld_ff;

   logic signed [DIFF_W-1:0]  diff_ff  [3];
   logic signed [DIFF_W-1:0]  diff_in  [3];
   logic signed [DPROD_W-1:0] dprod_ff [3];
   logic signed [DPROD_W-1:0] dprod_in [3];
   logic signed [RPROD_W-1:0] rprod_ff [3];
   logic signed [RPROD_W-1:0] rprod_in [3];
   logic [2:0][CW-1:0] p1_ff, p2_ff, p3_ff, d1_ff;
   logic [2:0][CW-1:0] p_in, d_in;
   logic signed [DOT_W-1:0] dot_ff, dot_in, den_ff, den_in;
   logic [DOT_W-1:0] rnd;
   front_type out_ff, out_in;

   assign p_in = {in_data.query_z, in_data.query_y, in_data.query_x};
   assign d_in = {in_data.ray_dz, in_data.ray_dy, in_data.ray_dx};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff_in[i]  = DIFF_W'($signed(p_in[i])) - DIFF_W'($signed(plane.base[i]));
         dprod_in[i] = diff_ff[i] * $signed(plane.norm[i]);
         rprod_in[i] = $signed(d1_ff[i]) * $signed(plane.norm[i]);
      end
      dot_in = DOT_W'(dprod_ff[0]) + DOT_W'(dprod_ff[1]) + DOT_W'(dprod_ff[2]);
      den_in = DOT_W'(rprod_ff[0]) + DOT_W'(rprod_ff[1]) + DOT_W'(rprod_ff[2]);
   end

   always_comb begin
      rnd            = dot_ff + HALF30;
      out_in.sd      = rnd[DOT_W-1:NORM_FRAC];
      out_in.below   = dot_ff[DOT_W-1];
      out_in.p       = p3_ff;
      out_in.un      = dot_ff[DOT_W-1] ? UW'(-dot_ff) : UW'(dot_ff);
      out_in.ud      = den_ff[DOT_W-1] ? UW'(-den_ff) : UW'(den_ff);
      out_in.no_hit  = (den_ff == '0);
      // The numerator is the negated dot product.
      out_in.neg     = (!dot_ff[DOT_W-1] && dot_ff != '0) ^ den_ff[DOT_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            diff_ff[i]  <= diff_in[i];
            dprod_ff[i] <= dprod_in[i];
            rprod_ff[i] <= rprod_in[i];
         end
         p1_ff  <= p_in;
         d1_ff  <= d_in;
         p2_ff  <= p1_ff;
         p3_ff  <= p2_ff;
         dot_ff <= dot_in;
         den_ff <= den_in;
         out_ff <= out_in;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_data  = out_ff;

endmodule

// ===== rtl/core/ppq_geom.sv =====
// ----------------------------------------------------------------------------
// ppq_geom : foot point and mirror image
// Two stages: sd times normal, then rounding, subtraction and saturation.
// ----------------------------------------------------------------------------
module ppq_geom import ppq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  logic       in_valid,
   input  front_type  in_data,
   input  plane_type  plane,
   output logic       out_valid,
   output div_in_type out_data
);

   localparam logic [PROD_W-1:0] HALF30 = PROD_W'(1) << (NORM_FRAC - 1);
   localparam logic [PROD_W-1:0] HALF29 = PROD_W'(1) << (NORM_FRAC - 2);

   logic [1:0] vld_ff;
   logic signed [PROD_W-1:0] prod_ff [3];
   logic signed [PROD_W-1:0] prod_in [3];
   front_type  f_ff;
   div_in_type out_ff, out_in;
   logic [CW-1:0]   sd_sat;
   logic [CW-2:0]   abs_sat;
   logic [SD_W-1:0] mag;
   logic [CW-1:0]   foot  [3];
   logic [CW-1:0]   image [3];
   logic [PROD_W-1:0] r30 [3];
   logic [PROD_W-1:0] r29 [3];
   logic [EXT_W-1:0]  pe  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = $signed(in_data.sd) * $signed(plane.norm[i]);
      end
   end

   always_comb begin
      sd_sat  = sat_coord(EXT_W'($signed(f_ff.sd)));
      mag     = f_ff.sd[SD_W-1] ? -f_ff.sd : f_ff.sd;
      abs_sat = (mag[SD_W-1:CW-1] != '0) ? SMAX[CW-2:0] : mag[CW-2:0];
      for (int i = 0; i < 3; i++) begin
         pe[i]    = EXT_W'($signed(f_ff.p[i]));
         r30[i]   = prod_ff[i] + HALF30;
         r29[i]   = prod_ff[i] + HALF29;
         foot[i]  = sat_coord(pe[i] - EXT_W'($signed(r30[i][PROD_W-1:NORM_FRAC])));
         image[i] = sat_coord(pe[i] - EXT_W'($signed(r29[i][PROD_W-1:NORM_FRAC-1])));
      end
      out_in.un               = f_ff.un;
      out_in.ud               = f_ff.ud;
      out_in.neg              = f_ff.neg;
      out_in.no_hit           = f_ff.no_hit;
      out_in.rsp.signed_dist  = sd_sat;
      out_in.rsp.abs_dist     = abs_sat;
      out_in.rsp.foot_x       = foot[0];
      out_in.rsp.foot_y       = foot[1];
      out_in.rsp.foot_z       = foot[2];
      out_in.rsp.below_plane  = f_ff.below;
      out_in.rsp.image_x      = image[0];
      out_in.rsp.image_y      = image[1];
      out_in.rsp.image_z      = image[2];
      out_in.rsp.hit_param    = '0;
      out_in.rsp.no_hit       = f_ff.no_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= prod_in[i];
         end
         f_ff   <= in_data;
         out_ff <= out_in;
      end
   end

   assign out_valid = vld_ff[1];
   assign out_data  = out_ff;

endmodule

// ===== rtl/core/ppq_div.sv =====
// ----------------------------------------------------------------------------
// ppq_div : pipelined restoring divider for the ray parameter
// One set-up stage, one quotient bit per stage, one saturation stage.
// ----------------------------------------------------------------------------
module ppq_div import ppq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  logic       in_valid,
   input  div_in_type in_data,
   output logic       out_valid,
   output rsp_type    out_data
);

   localparam int DW = UW + QW;

   typedef struct packed {
      logic [RW-1:0] r;
      logic [UW-1:0] ud;
      logic [QW-1:0] low;
      logic [QW-1:0] q;
      logic          ovf;
      logic          neg;
      logic          no_hit;
      rsp_type       rsp;
   } stage_type;

   function automatic stage_type div_step(input stage_type s);
      stage_type     n;
      logic [RW-1:0] rs;
      n  = s;
      rs = {s.r[RW-2:0], s.low[QW-1]};
      n.low = {s.low[QW-2:0], 1'b0};
      if (rs >= RW'(s.ud)) begin
         n.r = rs - RW'(s.ud);
         n.q = {s.q[QW-2:0], 1'b1};
      end else begin
         n.r = rs;
         n.q = {s.q[QW-2:0], 1'b0};
      end
      return n;
   endfunction

   logic [QW+1:0] vld_ff;
   stage_type st_ff [QW+1];
   stage_type st0_in;
   rsp_type   out_ff, out_in;
   logic [QW-1:0] lim, qm;
   logic [UW-1:0] un_lo;

   always_comb begin
      un_lo         = in_data.un << COORD_FRAC_BITS;
      st0_in.r      = RW'(in_data.un >> (QW - COORD_FRAC_BITS));
      st0_in.ud     = in_data.ud;
      st0_in.low    = un_lo[QW-1:0];
      st0_in.q      = '0;
      // Quotient of 2^32 or more always saturates.
      st0_in.ovf    = DW'(in_data.un) >= (DW'(in_data.ud) << (QW - COORD_FRAC_BITS));
      st0_in.neg    = in_data.neg;
      st0_in.no_hit = in_data.no_hit;
      st0_in.rsp    = in_data.rsp;
   end

   always_comb begin
      lim    = st_ff[QW].neg ? SMIN : SMAX;
      qm     = (st_ff[QW].ovf || st_ff[QW].q > lim) ? lim : st_ff[QW].q;
      out_in = st_ff[QW].rsp;
      if (st_ff[QW].no_hit) begin
         out_in.hit_param = SMAX;
      end else begin
         out_in.hit_param = st_ff[QW].neg ? -qm : qm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[QW:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= st0_in;
         for (int k = 0; k < QW; k++) begin
            st_ff[k+1] <= div_step(st_ff[k]);
         end
         out_ff <= out_in;
      end
   end

   assign out_valid = vld_ff[QW+1];
   assign out_data  = out_ff;

endmodule

// ===== rtl/core/point_plane_query_engine_top.sv =====
// ----------------------------------------------------------------------------
// point_plane_query_engine_top : point and ray queries against one plane
// Returns signed and absolute distance, foot point, mirror image and the
// ray parameter of each query item against the configured plane.
// ----------------------------------------------------------------------------
// Usage. Software writes the plane through the csr_ port: indices 0 to 2 set
// the base point (Q16.16), indices 3 to 5 the unit normal (Q2.30); other
// indices are ignored. Writes must be made only while no item is in flight;
// the block itself does not enforce this. Each item on the req_ channel
// carries a query point and a ray direction; exactly one item leaves on the
// rsp_ channel for each item taken, in order. Four front-end stages form the
// dot products and the signed distance, two stages form the foot point and
// the image, and the ray parameter divider takes one set-up stage, 32 stages
// of one quotient bit each and a final saturation stage. One item can enter
// in every cycle unless rsp_stall holds a result, so the sustained rate is
// one item per cycle; the pipeline depth is set by the bit-per-stage divider.
// The whole pipeline moves forward together unless a result waits at the
// output while rsp_stall is high; then every stage holds and req_stall is
// raised, so nothing is lost or repeated. Reset clears every valid bit and
// returns the plane to base (0,0,0) and normal (0,0,1).
// ----------------------------------------------------------------------------
module point_plane_query_engine_top import ppq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CW-1:0]        csr_wdata
);

   // Plane after reset: base at the origin, normal along +z.
   localparam logic [CW-1:0] NORM_Z_RESET = CW'(1) << NORM_FRAC;
   localparam plane_type PLANE_RESET = '{base: '0,
                                         norm: {NORM_Z_RESET, {(2*CW){1'b0}}}};

   // Plane registers, written one field at a time.
   plane_type plane_ff, plane_in;

   // Global advance: every stage moves unless the held result is refused.
   logic       adv;
   logic       front_valid, geom_valid;
   front_type  front_data;
   div_in_type geom_data;

   always_comb begin
      plane_in = plane_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_BASE_X: plane_in.base[0] = csr_wdata;
            CSR_BASE_Y: plane_in.base[1] = csr_wdata;
            CSR_BASE_Z: plane_in.base[2] = csr_wdata;
            CSR_NORM_X: plane_in.norm[0] = csr_wdata;
            CSR_NORM_Y: plane_in.norm[1] = csr_wdata;
            CSR_NORM_Z: plane_in.norm[2] = csr_wdata;
            default:    plane_in = plane_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= PLANE_RESET;
      end else begin
         plane_ff <= plane_in;
      end
   end

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   ppq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .plane     (plane_ff),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   ppq_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .plane     (plane_ff),
      .out_valid (geom_valid),
      .out_data  (geom_data)
   );

   ppq_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (geom_valid),
      .in_data   (geom_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

// ===== rtl/core/ppq_checker.sv =====
// ----------------------------------------------------------------------------
// ppq_checker : port-level checks of the point-plane query engine
// Watches the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
module ppq_checker import ppq_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rsp_type              rsp_data
);

   // A refused result stays and holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("refused result changed");

   // Input is held back only while a result is refused.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

   // A parallel ray reports the largest parameter.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_hit |-> rsp_data.hit_param == SMAX)
      else $error("no_hit with wrong hit_param");

   // Non-negative distance and its magnitude agree.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.signed_dist[CW-1] |->
         rsp_data.abs_dist == rsp_data.signed_dist[CW-2:0])
      else $error("abs_dist disagrees with signed_dist");

endmodule

bind point_plane_query_engine_top ppq_checker u_ppq_checker (.*);
